/* hw/rtl/afr_pkg.sv */
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the acknowledgement frame receiver
// Frame layout, register indexes, port widths and the structs passed between
// the configuration, parser and readiness blocks.
// ----------------------------------------------------------------------------
package afr_pkg;

	// frame layout: header, payload held for latching, trailing checksum
	localparam int unsigned FRAME_BYTES = 7;
	localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
	localparam int unsigned HOLD_DEPTH  = 4;
	localparam int unsigned HOLD_W      = $clog2(HOLD_DEPTH);

	localparam logic [7:0] HEAD_FIRST  = 8'h5A;
	localparam logic [7:0] HEAD_SECOND = 8'hA5;

	// beat kinds on the input stream
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MISSION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_BITS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_BITS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRETILT_BIT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS       = 3'd4;

	localparam logic [15:0] TIMEOUT_RESET = 16'd120;
	localparam logic [15:0] AGE_MAX       = 16'hFFFF;

	// result beat: 36 bits of fields padded to 40
	localparam int unsigned RES_W = 40;

	typedef struct packed {
		logic [7:0]  expected_mission;
		logic [7:0]  required_bits;
		logic [7:0]  fault_bits;
		logic [7:0]  pretilt_bit;
		logic [15:0] timeout_ms;
	} cfg_t;

	// acknowledgement state after a step
	typedef struct packed {
		logic        have_frame;
		logic [15:0] frame_age;
		logic [7:0]  sequence_b;
		logic [7:0]  status_b;
		logic [7:0]  mission_b;
		logic [7:0]  error_b;
	} ack_state_t;

	typedef struct packed {
		logic frame_accepted;
		logic checksum_error;
	} frame_evt_t;

endpackage

/* hw/rtl/afr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// afr_cfg_regs: configuration registers
// Write-only register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module afr_cfg_regs
	import afr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_mission <= '0;
			cfg_q.required_bits    <= '0;
			cfg_q.fault_bits       <= '0;
			cfg_q.pretilt_bit      <= '0;
			cfg_q.timeout_ms       <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPECTED_MISSION: cfg_q.expected_mission <= cfg_wdata[7:0];
				REG_REQUIRED_BITS:    cfg_q.required_bits    <= cfg_wdata[7:0];
				REG_FAULT_BITS:       cfg_q.fault_bits       <= cfg_wdata[7:0];
				REG_PRETILT_BIT:      cfg_q.pretilt_bit      <= cfg_wdata[7:0];
				REG_TIMEOUT_MS:       cfg_q.timeout_ms       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/afr_parser.sv */
// ----------------------------------------------------------------------------
// afr_parser: frame hunt, checksum and acknowledgement latch
// Holds the parser position, running sum, payload bytes, latched fields and
// frame age; presents the state after the current beat and its pulses.
// ----------------------------------------------------------------------------
module afr_parser
	import afr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	output ack_state_t ack_next,
	output frame_evt_t evt
);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       hold_q [HOLD_DEPTH];
	ack_state_t       ack_q;

	logic [POS_W-1:0] hold_off;
	logic             hold_we;
	logic             is_byte;

	assign is_byte  = (req_type == REQ_BYTE);
	assign hold_off = pos_q - POS_W'(2);

	// next-state logic for one beat
	always_comb begin
		pos_d    = pos_q;
		sum_d    = sum_q;
		ack_next = ack_q;
		evt      = '0;
		hold_we  = 1'b0;
		if (!is_byte) begin
			if (ack_q.frame_age != AGE_MAX)
				ack_next.frame_age = ack_q.frame_age + 16'd1;
		end else if (pos_q == '0) begin
			if (rx_byte == HEAD_FIRST) begin
				sum_d = rx_byte;
				pos_d = POS_W'(1);
			end
		end else if (pos_q == POS_W'(1)) begin
			priority if (rx_byte == HEAD_SECOND) begin
				sum_d = sum_q + rx_byte;
				pos_d = POS_W'(2);
			end else if (rx_byte == HEAD_FIRST) begin
				sum_d = rx_byte;
				pos_d = POS_W'(1);
			end else begin
				pos_d = '0;
			end
		end else if (int'(pos_q) < int'(FRAME_BYTES) - 1) begin
			hold_we = (int'(hold_off) < int'(HOLD_DEPTH));
			sum_d   = sum_q + rx_byte;
			pos_d   = pos_q + POS_W'(1);
		end else begin
			// checksum byte closes the frame
			pos_d = '0;
			if (sum_q != rx_byte) begin
				evt.checksum_error = 1'b1;
			end else begin
				evt.frame_accepted  = 1'b1;
				ack_next.sequence_b = hold_q[0];
				ack_next.status_b   = hold_q[1];
				ack_next.mission_b  = hold_q[2];
				ack_next.error_b    = hold_q[3];
				ack_next.have_frame = 1'b1;
				ack_next.frame_age  = '0;
			end
		end
	end

	// control and latched state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			ack_q <= '0;
		end else if (step) begin
			pos_q <= pos_d;
			sum_q <= sum_d;
			ack_q <= ack_next;
		end
	end

	// payload bytes, no reset
	always_ff @(posedge clk) begin
		if (step && hold_we)
			hold_q[hold_off[HOLD_W-1:0]] <= rx_byte;
	end

endmodule

/* hw/rtl/afr_ready.sv */
// ----------------------------------------------------------------------------
// afr_ready: readiness flags
// Balance and pre-tilt readiness from the acknowledgement state and config.
// ----------------------------------------------------------------------------
module afr_ready
	import afr_pkg::*;
(
	input  cfg_t       cfg,
	input  ack_state_t ack,
	output logic       balance_ready,
	output logic       pretilt_ready
);

	logic fresh;
	logic mission_ok;
	logic no_fault;
	logic req_ok;

	assign fresh      = ack.have_frame && (ack.frame_age <= cfg.timeout_ms);
	assign mission_ok = (ack.mission_b == cfg.expected_mission);
	assign no_fault   = ((ack.status_b & cfg.fault_bits) == 8'd0);
	assign req_ok     = ((ack.status_b & cfg.required_bits) == cfg.required_bits);

	assign balance_ready = fresh && mission_ok && no_fault && req_ok;
	assign pretilt_ready = balance_ready && ((ack.status_b & cfg.pretilt_bit) != 8'd0);

endmodule

/* hw/rtl/ack_frame_receiver.sv */
// ----------------------------------------------------------------------------
// ack_frame_receiver: acknowledgement frame receiver with readiness flags
// Input beats are UART bytes or 1 ms ticks; every beat yields one result.
// ----------------------------------------------------------------------------
// Each input beat is either a received byte (s_tuser 0) or a millisecond tick
// (s_tuser 1) and produces exactly one result beat. The block takes one beat
// per clock while m_tready stays high: a beat is held in the input register,
// its effect on the parser and latched state is computed from that register,
// and the result is registered in the output register and held until taken.
// Frames are 0x5A 0xA5, four payload bytes and an 8-bit sum of all earlier
// bytes. Readiness and acknowledgement fields show the state after the beat.
// Configuration writes are to be made only while no beat is in flight.
module ack_frame_receiver
	import afr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic                  s_tuser,   // [0] req_type
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] frame_accepted, [1] checksum_error, [2] balance_ready,
	// [3] pretilt_ready, [11:4] ack_sequence, [19:12] ack_status,
	// [27:20] ack_mission, [35:28] ack_error, [39:36] zero
	output logic [RES_W-1:0]      m_tdata,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic             valid_s1;
	logic             type_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             m_valid_q;
	logic [RES_W-1:0] result_q;

	cfg_t             cfg;
	ack_state_t       ack_next;
	frame_evt_t       evt;
	logic             balance_ready;
	logic             pretilt_ready;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			type_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	afr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	afr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.req_type (type_s1),
		.rx_byte  (byte_s1),
		.ack_next (ack_next),
		.evt      (evt)
	);

	afr_ready u_ready (
		.cfg           (cfg),
		.ack           (ack_next),
		.balance_ready (balance_ready),
		.pretilt_ready (pretilt_ready)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= {4'b0, ack_next.error_b, ack_next.mission_b,
				ack_next.status_b, ack_next.sequence_b, pretilt_ready,
				balance_ready, evt.checksum_error, evt.frame_accepted};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = result_q;

	// a frame ends good or bad, never both
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(result_q[0] && result_q[1]))
		else $error("frame_accepted and checksum_error both set");

	// a tick never completes a frame
	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (type_s1 == REQ_TICK) |=> m_valid_q && !result_q[0] && !result_q[1])
		else $error("tick produced a frame pulse");

	// pre-tilt readiness implies balance readiness
	a_pretilt: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && result_q[3] |-> result_q[2])
		else $error("pretilt_ready without balance_ready");

	// a beat held in the input register is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(type_s1))
		else $error("stalled input beat lost");

endmodule

/* tb/ack_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ack_frame_receiver_tb: self-checking testbench of the ack frame receiver
// Drives byte and tick beats, keeps its own copy of the parser, latch and
// readiness logic, and checks every result beat field by field against the
// expected result queued when the input beat was taken. Covers header
// restarts, broken headers, bad checksums, register extremes, back-pressure
// and frame age timeout, under random idling on both streams.
// ----------------------------------------------------------------------------
module ack_frame_receiver_tb;
	import afr_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned HOLD_OFF_LEN   = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;   // [7:0] rx_byte
	logic                  s_tuser;   // [0] req_type
	logic                  m_tvalid;
	logic                  m_tready;
	// [0] frame_accepted, [1] checksum_error, [2] balance_ready,
	// [3] pretilt_ready, [11:4] ack_sequence, [19:12] ack_status,
	// [27:20] ack_mission, [35:28] ack_error
	logic [RES_W-1:0]      m_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// one expected result beat
	typedef struct {
		bit       accepted;
		bit       cksum_bad;
		bit       balance;
		bit       pretilt;
		bit [7:0] seq_b;
		bit [7:0] status_b;
		bit [7:0] mission_b;
		bit [7:0] error_b;
	} ack_beat_t;

	ack_beat_t   expected_acks[$];
	int unsigned fail_count;
	int unsigned beats_sent;
	int unsigned stall_cycles;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_left;

	// shadow of the receiver state and registers
	cfg_t        shadow_cfg;
	int unsigned rx_pos;
	bit [7:0]    rx_sum;
	bit [7:0]    rx_hold [HOLD_DEPTH];
	bit [7:0]    lat_seq;
	bit [7:0]    lat_status;
	bit [7:0]    lat_mission;
	bit [7:0]    lat_error;
	bit          lat_valid;
	bit [15:0]   lat_age;

	ack_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// advance the shadow state by one beat and return the result it yields
	function automatic ack_beat_t predict_ack(logic kind, logic [7:0] b);
		ack_beat_t r;
		r = '{default: 0};
		if (kind == REQ_TICK) begin
			if (lat_age != AGE_MAX)
				lat_age++;
		end else if (rx_pos == 0) begin
			if (b == HEAD_FIRST) begin
				rx_sum = b;
				rx_pos = 1;
			end
		end else if (rx_pos == 1) begin
			// 0xA5 completes the header, a second 0x5A restarts it, anything else drops it
			if (b == HEAD_SECOND) begin
				rx_sum += b;
				rx_pos = 2;
			end else if (b == HEAD_FIRST) begin
				rx_sum = b;
			end else begin
				rx_pos = 0;
			end
		end else if (rx_pos + 1 < FRAME_BYTES) begin
			if (rx_pos - 2 < HOLD_DEPTH)
				rx_hold[rx_pos - 2] = b;
			rx_sum += b;
			rx_pos++;
		end else begin
			// checksum byte
			rx_pos = 0;
			if (rx_sum != b) begin
				r.cksum_bad = 1'b1;
			end else begin
				lat_seq     = rx_hold[0];
				lat_status  = rx_hold[1];
				lat_mission = rx_hold[2];
				lat_error   = rx_hold[3];
				lat_valid   = 1'b1;
				lat_age     = '0;
				r.accepted  = 1'b1;
			end
		end
		r.balance = lat_valid && lat_age <= shadow_cfg.timeout_ms &&
			lat_mission == shadow_cfg.expected_mission &&
			(lat_status & shadow_cfg.fault_bits) == 8'h00 &&
			(lat_status & shadow_cfg.required_bits) == shadow_cfg.required_bits;
		r.pretilt   = r.balance && (lat_status & shadow_cfg.pretilt_bit) != 8'h00;
		r.seq_b     = lat_seq;
		r.status_b  = lat_status;
		r.mission_b = lat_mission;
		r.error_b   = lat_error;
		return r;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// offer one beat, with random idle cycles ahead of it
	task automatic send_item(input logic kind, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		expected_acks.push_back(predict_ack(kind, b));
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(REQ_BYTE, b);
	endtask

	// tick beats carry random data, which the block ignores
	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(REQ_TICK, 8'($urandom));
	endtask

	task automatic send_frame(input logic [7:0] seq_b, input logic [7:0] status_b,
		input logic [7:0] mission_b, input logic [7:0] error_b, input bit corrupt);
		logic [7:0] sum;
		sum = HEAD_FIRST + HEAD_SECOND + seq_b + status_b + mission_b + error_b;
		if (corrupt)
			sum ^= 8'h01 << $urandom_range(7);
		send_byte(HEAD_FIRST);
		send_byte(HEAD_SECOND);
		send_byte(seq_b);
		send_byte(status_b);
		send_byte(mission_b);
		send_byte(error_b);
		send_byte(sum);
	endtask

	// random payload, mostly one that meets the current readiness rules
	task automatic send_random_frame(input bit corrupt);
		logic [7:0] mission_b;
		logic [7:0] status_b;
		mission_b = ($urandom_range(3) != 0) ? shadow_cfg.expected_mission :
			8'($urandom);
		status_b = 8'($urandom);
		if ($urandom_range(3) != 0)
			status_b = (status_b | shadow_cfg.required_bits) & ~shadow_cfg.fault_bits;
		send_frame(8'($urandom), status_b, mission_b, 8'($urandom), corrupt);
	endtask

	// stop offering and wait until every expected result has come back
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_acks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_EXPECTED_MISSION: shadow_cfg.expected_mission = value[7:0];
			REG_REQUIRED_BITS:    shadow_cfg.required_bits    = value[7:0];
			REG_FAULT_BITS:       shadow_cfg.fault_bits       = value[7:0];
			REG_PRETILT_BIT:      shadow_cfg.pretilt_bit      = value[7:0];
			REG_TIMEOUT_MS:       shadow_cfg.timeout_ms       = value;
			default: ;
		endcase
	endtask

	// new random setting of all registers, extremes included
	task automatic randomize_regs();
		logic [15:0] tmo;
		logic [7:0]  req;
		logic [7:0]  flt;
		logic [7:0]  pre;
		case ($urandom_range(4))
			0: tmo = 16'd0;
			1: tmo = 16'($urandom_range(1, 8));
			2: tmo = 16'($urandom_range(9, 40));
			3: tmo = TIMEOUT_RESET;
			default: tmo = 16'd65534;
		endcase
		case ($urandom_range(3))
			0: req = 8'h00;
			1: req = 8'hFF;
			2: req = 8'($urandom);
			default: req = 8'($urandom) & 8'($urandom);
		endcase
		case ($urandom_range(3))
			0: flt = 8'h00;
			1: flt = 8'hFF;
			default: flt = 8'($urandom) & ~req;
		endcase
		case ($urandom_range(3))
			0: pre = 8'h00;
			1: pre = 8'hFF;
			default: pre = 8'($urandom);
		endcase
		// upper data bits of the byte registers are junk on purpose
		write_reg(REG_EXPECTED_MISSION, {8'($urandom), 8'($urandom)});
		write_reg(REG_REQUIRED_BITS, {8'($urandom), req});
		write_reg(REG_FAULT_BITS, {8'($urandom), flt});
		write_reg(REG_PRETILT_BIT, {8'($urandom), pre});
		write_reg(REG_TIMEOUT_MS, tmo);
	endtask

	task automatic test_directed();
		send_ticks(1);                       // tick before any frame
		send_byte(HEAD_FIRST);
		send_byte(8'h00);                    // broken header
		send_byte(HEAD_FIRST);               // repeated 0x5A restarts header
		send_frame(8'h01, 8'hFF, 8'h00, 8'h80, 1'b0);
		send_frame(8'h00, 8'h00, 8'hFF, 8'h00, 1'b1);   // bad checksum
		send_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
		send_item(REQ_TICK, 8'hFF);
		send_item(REQ_TICK, 8'h00);
	endtask

	task automatic test_register_writes();
		wait_idle();
		write_reg(REG_EXPECTED_MISSION, 16'hFFFF);
		write_reg(REG_REQUIRED_BITS, 16'h00FF);
		write_reg(REG_FAULT_BITS, 16'hFF00);
		write_reg(REG_PRETILT_BIT, 16'h00FF);
		write_reg(REG_TIMEOUT_MS, 16'd0);
		// unmapped index must leave every register alone
		write_reg(REG_UNMAPPED, 16'hFFFF);
		send_frame(8'h5A, 8'hFF, 8'hFF, 8'hA5, 1'b0);
		send_ticks(2);                       // zero timeout: one tick is stale
		wait_idle();
		write_reg(REG_EXPECTED_MISSION, 16'hAB00);
		write_reg(REG_REQUIRED_BITS, 16'h0000);
		write_reg(REG_FAULT_BITS, 16'h00FE);
		write_reg(REG_PRETILT_BIT, 16'h0001);
		write_reg(REG_TIMEOUT_MS, 16'd65534);
		send_frame(8'h10, 8'h00, 8'h00, 8'h00, 1'b0);
		send_frame(8'h11, 8'h01, 8'h00, 8'h00, 1'b0);
		send_frame(8'h12, 8'h80, 8'h00, 8'h00, 1'b0);   // fault bit set
		wait_idle();
		write_reg(REG_FAULT_BITS, 16'h0000);
		write_reg(REG_TIMEOUT_MS, TIMEOUT_RESET);
	endtask

	// well-formed frames with random content, plus ticks, noise and broken frames
	task automatic test_random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned batch_end;
		int unsigned pick;
		int unsigned n;
		stop_at = beats_sent + count;
		while (beats_sent < stop_at) begin
			wait_idle();
			randomize_regs();
			batch_end = beats_sent + $urandom_range(30, 60);
			while (beats_sent < batch_end) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					send_random_frame(1'b0);
				end else if (pick < 63) begin
					send_random_frame(1'b1);
				end else if (pick < 75) begin
					send_ticks($urandom_range(1, 6));
				end else if (pick < 82) begin
					// ticks around the timeout edge
					if (shadow_cfg.timeout_ms <= 40)
						send_ticks(shadow_cfg.timeout_ms + $urandom_range(0, 2));
					else
						send_ticks($urandom_range(1, 6));
				end else if (pick < 90) begin
					// noise, with header bytes mixed in
					n = $urandom_range(1, 5);
					repeat (n) begin
						case ($urandom_range(3))
							0: send_byte(HEAD_FIRST);
							1: send_byte(HEAD_SECOND);
							default: send_byte(8'($urandom));
						endcase
					end
				end else if (pick < 95) begin
					// truncated frame; the next bytes fall into its payload
					send_byte(HEAD_FIRST);
					send_byte(HEAD_SECOND);
					n = $urandom_range(0, 3);
					repeat (n) send_byte(8'($urandom));
				end else begin
					repeat ($urandom_range(1, 3)) send_byte(HEAD_FIRST);
					send_random_frame(1'b0);
				end
			end
		end
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_backpressure();
		int unsigned saved_pct;
		wait_idle();
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_left = HOLD_OFF_LEN;
		repeat (6) send_random_frame(1'b0);
		send_ticks(4);
		send_idle_pct = saved_pct;
		wait_idle();
	endtask

	// a fresh frame goes stale once its age passes a short timeout
	task automatic test_age_timeout();
		wait_idle();
		write_reg(REG_REQUIRED_BITS, 16'h0003);
		write_reg(REG_FAULT_BITS, 16'h0080);
		write_reg(REG_PRETILT_BIT, 16'h0010);
		write_reg(REG_TIMEOUT_MS, 16'd5);
		send_frame(8'h77, 8'h13, shadow_cfg.expected_mission, 8'h00, 1'b0);
		send_ticks(8);
		wait_idle();
		write_reg(REG_TIMEOUT_MS, TIMEOUT_RESET);
	endtask

	// result checker
	always @(posedge clk) begin : check_results
		ack_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_acks.size() == 0) begin
				$error("result beat with nothing expected: 0x%0h", m_tdata);
				fail_count++;
			end else begin
				want = expected_acks.pop_front();
				compare_field("frame_accepted", want.accepted, m_tdata[0]);
				compare_field("checksum_error", want.cksum_bad, m_tdata[1]);
				compare_field("balance_ready", want.balance, m_tdata[2]);
				compare_field("pretilt_ready", want.pretilt, m_tdata[3]);
				compare_field("ack_sequence", want.seq_b, m_tdata[11:4]);
				compare_field("ack_status", want.status_b, m_tdata[19:12]);
				compare_field("ack_mission", want.mission_b, m_tdata[27:20]);
				compare_field("ack_error", want.error_b, m_tdata[35:28]);
			end
		end
	end

	// result side ready, with random stalls and long hold-offs
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("** ack_frame_receiver: FAILED **");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = REQ_BYTE;
		m_tready      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_EXPECTED_MISSION;
		cfg_wdata     = '0;
		fail_count    = 0;
		beats_sent    = 0;
		stall_cycles  = 0;
		hold_left     = 0;
		send_idle_pct = 27;
		recv_idle_pct = 87;

		shadow_cfg.expected_mission = 8'h00;
		shadow_cfg.required_bits    = 8'h00;
		shadow_cfg.fault_bits       = 8'h00;
		shadow_cfg.pretilt_bit      = 8'h00;
		shadow_cfg.timeout_ms       = TIMEOUT_RESET;
		rx_pos      = 0;
		rx_sum      = '0;
		rx_hold     = '{default: 8'h00};
		lat_seq     = '0;
		lat_status  = '0;
		lat_mission = '0;
		lat_error   = '0;
		lat_valid   = 1'b0;
		lat_age     = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_writes();
		test_random_traffic(400);

		send_idle_pct = 87;
		recv_idle_pct = 27;
		test_random_traffic(400);
		test_backpressure();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(400);
		test_age_timeout();

		wait_idle();
		if (fail_count == 0)
			$display("** ack_frame_receiver: PASSED **");
		else
			$display("** ack_frame_receiver: FAILED **");
		$finish;
	end

endmodule
